// File: rtl/cookie_header_tokenizer_defines.svh
// Assertion macros for the cookie header tokenizer checker.
// Expects signals named clock and reset in the scope of use.
`ifndef COOKIE_HEADER_TOKENIZER_DEFINES_SVH
`define COOKIE_HEADER_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CHT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cht_pkg.sv
// Shared types and constants for the cookie header tokenizer.
// No dependencies; used by the controller, datapath and top level.
package cht_pkg;

   localparam int NAME_MAX_DEF = 32;
   localparam int WS_MAX_DEF   = 16;

   // Character codes
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   // Token kinds on the result stream
   typedef enum logic [1:0] {
      KIND_NAME  = 2'd0,
      KIND_VALUE = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   // Parse mode across header bytes
   typedef enum logic [2:0] {
      MODE_SKIP     = 3'd0,
      MODE_NAME     = 3'd1,
      MODE_LEAD     = 3'd2,
      MODE_QUOTED   = 3'd3,
      MODE_UNQUOTED = 3'd4
   } mode_type;

   // Sequencer states within one item
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DECODE,
      SEQ_NAME_RD,
      SEQ_NAME_OUT,
      SEQ_SPACE,
      SEQ_VALUE,
      SEQ_END
   } seq_type;

   // Source of the next result item
   typedef enum logic [1:0] {
      SRC_NAME,
      SRC_SPACE,
      SRC_VALUE,
      SRC_END
   } src_type;

   typedef struct packed {
      logic    latch;
      logic    pair_start;
      logic    supp_set;
      logic    name_put;
      logic    space_push;
      logic    space_pop;
      logic    space_clear;
      logic    replay_clear;
      logic    replay_next;
      logic    out_load;
      src_type out_src;
      logic    out_last;
   } cmd_type;

   typedef struct packed {
      logic is_eq;
      logic is_semi;
      logic is_quote;
      logic is_ws;
      logic fin;
      logic trim_zero;
      logic replay_last;
      logic space_zero;
      logic space_one;
      logic supp;
   } status_type;

endpackage

// File: rtl/cookie_header_tokenizer.sv
// Cookie header tokenizer: takes one header byte per item on req_ and
// returns name/value bytes and end-of-pair marks as items on rsp_. An item
// is latched in the idle state and decoded in the decode state. Each name
// byte replayed on '=' then passes a read of the name memory, then the
// result register; each held space, value byte or end mark is loaded into
// the result register directly. The result register sets the pace when
// rsp_tready is low. The next item is accepted as soon as the last result
// of the previous one sits in the result register. No clearing pass after reset.
module cookie_header_tokenizer #(
   parameter int NAME_MAX = cht_pkg::NAME_MAX_DEF,
   parameter int WS_MAX   = cht_pkg::WS_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] header_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] token_byte, [8] was_truncated, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] token_kind
   output logic        rsp_tlast    // run_last
);

   cht_pkg::cmd_type    cmd;
   cht_pkg::status_type status;
   cht_pkg::kind_type   out_kind;
   logic [7:0]          out_byte;
   logic                out_trunc;
   logic                out_last;

   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   cht_datapath #(
      .NAME_MAX (NAME_MAX),
      .WS_MAX   (WS_MAX)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_byte   (req_tdata),
      .in_fin    (req_tlast),
      .cmd       (cmd),
      .status    (status),
      .out_kind  (out_kind),
      .out_byte  (out_byte),
      .out_trunc (out_trunc),
      .out_last  (out_last)
   );

   // Pack the result item
   assign rsp_tdata = {7'b0, out_trunc, out_byte};
   assign rsp_tuser = out_kind;
   assign rsp_tlast = out_last;

endmodule

// File: rtl/cht_datapath.sv
// Datapath of the cookie header tokenizer: input latch, name memory,
// pair counters, held whitespace and the result register. Uses cht_pkg.
module cht_datapath #(
   parameter int NAME_MAX = cht_pkg::NAME_MAX_DEF,
   parameter int WS_MAX   = cht_pkg::WS_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         in_byte,
   input  logic               in_fin,
   input  cht_pkg::cmd_type   cmd,
   output cht_pkg::status_type status,
   output cht_pkg::kind_type  out_kind,
   output logic [7:0]         out_byte,
   output logic               out_trunc,
   output logic               out_last
);

   localparam int LEN_W = $clog2(NAME_MAX + 1);
   localparam int IDX_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
   localparam int CNT_W = $clog2(WS_MAX + 1);

   logic [7:0]        byte_ff;
   logic              fin_ff;
   logic [7:0]        name_mem [NAME_MAX];
   logic [7:0]        rd_ff;
   logic [LEN_W-1:0]  name_len_ff, name_len_in;
   logic [LEN_W-1:0]  trim_len_ff, trim_len_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  space_cnt_ff, space_cnt_in;
   logic [WS_MAX-1:0] space_kinds_ff, space_kinds_in;
   logic              supp_ff, supp_in;
   logic              ovf_ff, ovf_in;
   cht_pkg::kind_type out_kind_ff;
   logic [7:0]        out_byte_ff;
   logic              out_trunc_ff;
   logic              out_last_ff;

   logic              is_ws;
   logic              is_tab;
   logic [LEN_W-1:0]  len_eff;
   logic [LEN_W-1:0]  trim_eff;
   logic              name_full;
   logic              space_full;
   logic              name_write;

   // Classify the latched byte
   assign is_tab = (byte_ff == cht_pkg::CH_TAB);
   assign is_ws  = is_tab || (byte_ff == cht_pkg::CH_SPACE);

   // A new pair starts from empty counters in the same cycle as its first byte
   assign len_eff    = cmd.pair_start ? '0 : name_len_ff;
   assign trim_eff   = cmd.pair_start ? '0 : trim_len_ff;
   assign name_full  = (len_eff == LEN_W'(NAME_MAX));
   assign space_full = (space_cnt_ff == CNT_W'(WS_MAX));
   assign name_write = cmd.name_put && !name_full;

   // Name and trimmed length
   always_comb begin
      name_len_in = len_eff;
      trim_len_in = trim_eff;
      if (name_write) begin
         name_len_in = len_eff + LEN_W'(1);
         if (!is_ws) begin
            trim_len_in = len_eff + LEN_W'(1);
         end
      end
   end

   // Pair flags
   always_comb begin
      ovf_in  = cmd.pair_start ? 1'b0 : ovf_ff;
      supp_in = cmd.pair_start ? cmd.supp_set : supp_ff;
      if (cmd.name_put && name_full && !is_ws) begin
         ovf_in = 1'b1;
      end
      if (cmd.space_push && space_full) begin
         ovf_in = 1'b1;
      end
   end

   // Held whitespace: push at the top, drain from bit zero
   always_comb begin
      space_cnt_in   = space_cnt_ff;
      space_kinds_in = space_kinds_ff;
      if (cmd.pair_start || cmd.space_clear) begin
         space_cnt_in   = '0;
         space_kinds_in = '0;
      end else if (cmd.space_push && !space_full) begin
         space_cnt_in   = space_cnt_ff + CNT_W'(1);
         space_kinds_in = space_kinds_ff | (WS_MAX'(is_tab) << space_cnt_ff);
      end else if (cmd.space_pop) begin
         space_cnt_in   = space_cnt_ff - CNT_W'(1);
         space_kinds_in = space_kinds_ff >> 1;
      end
   end

   // Replay index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.replay_clear) begin
         idx_in = '0;
      end else if (cmd.replay_next) begin
         idx_in = idx_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_len_ff    <= '0;
         trim_len_ff    <= '0;
         idx_ff         <= '0;
         space_cnt_ff   <= '0;
         space_kinds_ff <= '0;
         supp_ff        <= 1'b0;
         ovf_ff         <= 1'b0;
      end else begin
         name_len_ff    <= name_len_in;
         trim_len_ff    <= trim_len_in;
         idx_ff         <= idx_in;
         space_cnt_ff   <= space_cnt_in;
         space_kinds_ff <= space_kinds_in;
         supp_ff        <= supp_in;
         ovf_ff         <= ovf_in;
      end
   end

   // Input latch
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         byte_ff <= in_byte;
         fin_ff  <= in_fin;
      end
   end

   // Name memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (name_write) begin
         name_mem[len_eff[IDX_W-1:0]] <= byte_ff;
      end
      rd_ff <= name_mem[idx_ff[IDX_W-1:0]];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_last_ff <= cmd.out_last;
         case (cmd.out_src)
            cht_pkg::SRC_NAME: begin
               out_kind_ff  <= cht_pkg::KIND_NAME;
               out_byte_ff  <= rd_ff;
               out_trunc_ff <= 1'b0;
            end
            cht_pkg::SRC_SPACE: begin
               out_kind_ff  <= cht_pkg::KIND_VALUE;
               out_byte_ff  <= space_kinds_ff[0] ? cht_pkg::CH_TAB : cht_pkg::CH_SPACE;
               out_trunc_ff <= 1'b0;
            end
            cht_pkg::SRC_VALUE: begin
               out_kind_ff  <= cht_pkg::KIND_VALUE;
               out_byte_ff  <= byte_ff;
               out_trunc_ff <= 1'b0;
            end
            default: begin
               out_kind_ff  <= cht_pkg::KIND_END;
               out_byte_ff  <= 8'h00;
               out_trunc_ff <= ovf_ff;
            end
         endcase
      end
   end

   assign out_kind  = out_kind_ff;
   assign out_byte  = out_byte_ff;
   assign out_trunc = out_trunc_ff;
   assign out_last  = out_last_ff;

   // Status towards the controller
   assign status.is_eq       = (byte_ff == cht_pkg::CH_EQ);
   assign status.is_semi     = (byte_ff == cht_pkg::CH_SEMI);
   assign status.is_quote    = (byte_ff == cht_pkg::CH_QUOTE);
   assign status.is_ws       = is_ws;
   assign status.fin         = fin_ff;
   assign status.trim_zero   = (trim_len_ff == '0);
   assign status.replay_last = ((idx_ff + LEN_W'(1)) == trim_len_ff);
   assign status.space_zero  = (space_cnt_ff == '0);
   assign status.space_one   = (space_cnt_ff == CNT_W'(1));
   assign status.supp        = supp_ff;

endmodule

// File: rtl/cht_ctrl.sv
// Controller of the cookie header tokenizer: parse mode, per-item plan
// and result sequencing. Uses cht_pkg; drives cht_datapath by commands.
module cht_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  cht_pkg::status_type status,
   output cht_pkg::cmd_type    cmd
);

   cht_pkg::seq_type  seq_ff, seq_in;
   cht_pkg::mode_type mode_ff, mode_in;
   logic plan_space_ff, plan_value_ff, plan_end_ff;
   logic plan_space_in, plan_value_in, plan_end_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // Decode results for the latched byte
   cht_pkg::mode_type dec_mid;
   cht_pkg::mode_type dec_mode;
   logic dec_put, dec_start, dec_sset, dec_push, dec_flush, dec_val;
   logic dec_finish, dec_rep, dec_supp, dec_fin_any, dec_clear;
   logic dec_name, dec_space, dec_value, dec_end;
   cht_pkg::seq_type after_name;
   cht_pkg::seq_type after_space;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (seq_ff == cht_pkg::SEQ_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Work out what the latched byte does to the parse mode and pair state
   always_comb begin
      dec_mid    = mode_ff;
      dec_put    = 1'b0;
      dec_start  = 1'b0;
      dec_sset   = 1'b0;
      dec_push   = 1'b0;
      dec_flush  = 1'b0;
      dec_val    = 1'b0;
      dec_finish = 1'b0;
      dec_rep    = 1'b0;
      dec_supp   = status.supp;
      unique case (mode_ff)
         cht_pkg::MODE_NAME: begin
            if (status.is_eq) begin
               dec_rep = !status.trim_zero;
               dec_mid = cht_pkg::MODE_LEAD;
            end else if (status.is_semi) begin
               dec_mid = cht_pkg::MODE_SKIP;
            end else begin
               dec_put = 1'b1;
            end
         end
         cht_pkg::MODE_LEAD: begin
            if (status.is_ws) begin
               dec_mid = cht_pkg::MODE_LEAD;
            end else if (status.is_quote) begin
               dec_mid = cht_pkg::MODE_QUOTED;
            end else if (status.is_semi) begin
               dec_finish = 1'b1;
            end else begin
               dec_mid = cht_pkg::MODE_UNQUOTED;
               dec_val = 1'b1;
            end
         end
         cht_pkg::MODE_QUOTED: begin
            if (status.is_quote) begin
               dec_finish = 1'b1;
            end else begin
               dec_val = 1'b1;
            end
         end
         cht_pkg::MODE_UNQUOTED: begin
            if (status.is_semi) begin
               dec_finish = 1'b1;
            end else if (status.is_ws) begin
               dec_push = 1'b1;
            end else begin
               dec_flush = 1'b1;
               dec_val   = 1'b1;
            end
         end
         default: begin
            // separator skipping, and any unused code
            dec_mid = cht_pkg::MODE_SKIP;
            if (!(status.is_ws || status.is_semi)) begin
               dec_start = 1'b1;
               if (status.is_eq) begin
                  dec_sset = 1'b1;
                  dec_supp = 1'b1;
                  dec_mid  = cht_pkg::MODE_LEAD;
               end else begin
                  dec_supp = 1'b0;
                  dec_mid  = cht_pkg::MODE_NAME;
                  dec_put  = 1'b1;
               end
            end
         end
      endcase

      // End of header closes an open value and drops an unfinished name
      dec_fin_any = dec_finish || (status.fin && (dec_mid != cht_pkg::MODE_SKIP) &&
                                   (dec_mid != cht_pkg::MODE_NAME));
      if (dec_fin_any || (status.fin && dec_mid == cht_pkg::MODE_NAME)) begin
         dec_mode = cht_pkg::MODE_SKIP;
      end else begin
         dec_mode = dec_mid;
      end

      dec_name  = dec_rep;
      dec_space = dec_flush && !dec_supp && !status.space_zero;
      dec_value = dec_val && !dec_supp;
      dec_end   = dec_fin_any && !dec_supp;
      dec_clear = (dec_fin_any || dec_flush) && !dec_space;
   end

   // Order of result groups: name, held spaces, value byte, end mark
   always_comb begin
      if (plan_space_ff) begin
         after_name = cht_pkg::SEQ_SPACE;
      end else if (plan_value_ff) begin
         after_name = cht_pkg::SEQ_VALUE;
      end else if (plan_end_ff) begin
         after_name = cht_pkg::SEQ_END;
      end else begin
         after_name = cht_pkg::SEQ_IDLE;
      end
      if (plan_value_ff) begin
         after_space = cht_pkg::SEQ_VALUE;
      end else if (plan_end_ff) begin
         after_space = cht_pkg::SEQ_END;
      end else begin
         after_space = cht_pkg::SEQ_IDLE;
      end
   end

   // Next state
   always_comb begin
      seq_in        = seq_ff;
      mode_in       = mode_ff;
      plan_space_in = plan_space_ff;
      plan_value_in = plan_value_ff;
      plan_end_in   = plan_end_ff;
      unique case (seq_ff)
         cht_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               seq_in = cht_pkg::SEQ_DECODE;
            end
         end
         cht_pkg::SEQ_DECODE: begin
            mode_in       = dec_mode;
            plan_space_in = dec_space;
            plan_value_in = dec_value;
            plan_end_in   = dec_end;
            if (dec_name) begin
               seq_in = cht_pkg::SEQ_NAME_RD;
            end else if (dec_space) begin
               seq_in = cht_pkg::SEQ_SPACE;
            end else if (dec_value) begin
               seq_in = cht_pkg::SEQ_VALUE;
            end else if (dec_end) begin
               seq_in = cht_pkg::SEQ_END;
            end else begin
               seq_in = cht_pkg::SEQ_IDLE;
            end
         end
         cht_pkg::SEQ_NAME_RD: begin
            seq_in = cht_pkg::SEQ_NAME_OUT;
         end
         cht_pkg::SEQ_NAME_OUT: begin
            if (out_free) begin
               seq_in = status.replay_last ? after_name : cht_pkg::SEQ_NAME_RD;
            end
         end
         cht_pkg::SEQ_SPACE: begin
            if (out_free && status.space_one) begin
               seq_in = after_space;
            end
         end
         cht_pkg::SEQ_VALUE: begin
            if (out_free) begin
               seq_in = plan_end_ff ? cht_pkg::SEQ_END : cht_pkg::SEQ_IDLE;
            end
         end
         cht_pkg::SEQ_END: begin
            if (out_free) begin
               seq_in = cht_pkg::SEQ_IDLE;
            end
         end
         default: begin
            seq_in = cht_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd         = '0;
      cmd.out_src = cht_pkg::SRC_END;
      unique case (seq_ff)
         cht_pkg::SEQ_IDLE: begin
            cmd.latch = req_valid;
         end
         cht_pkg::SEQ_DECODE: begin
            cmd.pair_start   = dec_start;
            cmd.supp_set     = dec_sset;
            cmd.name_put     = dec_put;
            cmd.space_push   = dec_push;
            cmd.space_clear  = dec_clear;
            cmd.replay_clear = 1'b1;
         end
         cht_pkg::SEQ_NAME_OUT: begin
            cmd.out_load    = out_free;
            cmd.replay_next = out_free;
            cmd.out_src     = cht_pkg::SRC_NAME;
            cmd.out_last    = status.replay_last && !plan_space_ff && !plan_value_ff &&
                              !plan_end_ff;
         end
         cht_pkg::SEQ_SPACE: begin
            cmd.out_load  = out_free;
            cmd.space_pop = out_free;
            cmd.out_src   = cht_pkg::SRC_SPACE;
            cmd.out_last  = status.space_one && !plan_value_ff && !plan_end_ff;
         end
         cht_pkg::SEQ_VALUE: begin
            cmd.out_load = out_free;
            cmd.out_src  = cht_pkg::SRC_VALUE;
            cmd.out_last = !plan_end_ff;
         end
         cht_pkg::SEQ_END: begin
            cmd.out_load = out_free;
            cmd.out_src  = cht_pkg::SRC_END;
            cmd.out_last = 1'b1;
         end
         default: begin
            cmd.latch = 1'b0;
         end
      endcase
   end

   // Hold a result until taken
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= cht_pkg::SEQ_IDLE;
         mode_ff       <= cht_pkg::MODE_SKIP;
         plan_space_ff <= 1'b0;
         plan_value_ff <= 1'b0;
         plan_end_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         mode_ff       <= mode_in;
         plan_space_ff <= plan_space_in;
         plan_value_ff <= plan_value_in;
         plan_end_ff   <= plan_end_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/cht_checker.sv
// Port-level checks for the cookie header tokenizer, bound to the top.
// Depends on cookie_header_tokenizer_defines.svh and cht_pkg.
`include "cookie_header_tokenizer_defines.svh"

module cht_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic [18:0] rsp_item;
   logic        rsp_stall;
   logic        rsp_end;

   // Group the result fields and name the interesting conditions
   assign rsp_item  = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_end   = rsp_tvalid && (rsp_tuser == cht_pkg::KIND_END);

   // A stalled result holds
   `CHT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_item), "stalled result changed")

   // An end mark closes the results of its item and carries no byte
   `CHT_ASSERT_IMPLIES(a_end_last, rsp_end, rsp_tlast && (rsp_tdata[7:0] == 8'h00), "bad end mark")

   // Only an end mark reports truncation
   `CHT_ASSERT_IMPLIES(a_trunc_end, rsp_tvalid && rsp_tdata[8], rsp_end, "truncation on a byte")

   // An accepted header byte is decoded before the next one is taken
   `CHT_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready, "item taken while decoding")

endmodule

bind cookie_header_tokenizer cht_checker u_checker (.*);
